>>> rtl/thp_pkg.sv
// ----------------------------------------------------------------------------
// thp_pkg
// shared types and constants for the sensor compensation pipeline
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam int NMUL      = 6;   // multiplier lanes per multiply stage
  localparam int DIV_STEPS = 64;  // quotient bits, one per divider stage
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIXED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_OFF  = 3'd5;

  typedef logic [NMUL-1:0][63:0] mvec_t;

  // per-item working set that travels down the pipeline
  typedef struct packed {
    logic [19:0] adc_t;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
    logic [63:0] ta;
    logic [63:0] tf;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [63:0] hx;
    logic [63:0] hu;
    logic [63:0] hv;
    logic [63:0] hw;
    logic [63:0] pnum;
    logic [63:0] pden;
    logic [63:0] pq;
    logic        dz;
    logic        qneg;
    logic [15:0] temp;
    logic [31:0] pres;
    logic [16:0] hres;
  } ctx_t;

endpackage

>>> rtl/thp_mul_stage.sv
// ----------------------------------------------------------------------------
// thp_mul_stage
// two-register multiply stage, 64x64 products modulo 2^64 on parallel lanes
// ----------------------------------------------------------------------------
module thp_mul_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  thp_pkg::ctx_t       ctx_i,
  input  thp_pkg::mvec_t      a_i,
  input  thp_pkg::mvec_t      b_i,
  output logic                valid_o,
  output thp_pkg::ctx_t       ctx_o,
  output thp_pkg::mvec_t      prod_o
);

  logic          v1_q, v2_q;
  thp_pkg::ctx_t ctx1_q, ctx2_q;
  thp_pkg::mvec_t ll_d, ll_q, prod_d, prod_q;
  logic [thp_pkg::NMUL-1:0][31:0] lh_d, lh_q, hl_d, hl_q;

  // partial products: low x low full width, cross terms only low halves
  always_comb begin
    for (int k = 0; k < thp_pkg::NMUL; k++) begin
      ll_d[k] = a_i[k][31:0] * b_i[k][31:0];
      lh_d[k] = a_i[k][31:0] * b_i[k][63:32];
      hl_d[k] = a_i[k][63:32] * b_i[k][31:0];
    end
  end

  always_comb begin
    for (int k = 0; k < thp_pkg::NMUL; k++) begin
      prod_d[k] = ll_q[k] + {lh_q[k] + hl_q[k], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q <= ctx_i;
      ctx2_q <= ctx1_q;
      ll_q   <= ll_d;
      lh_q   <= lh_d;
      hl_q   <= hl_d;
      prod_q <= prod_d;
    end
  end

  assign valid_o = v2_q;
  assign ctx_o   = ctx2_q;
  assign prod_o  = prod_q;

endmodule

>>> rtl/thp_div.sv
// ----------------------------------------------------------------------------
// thp_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module thp_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  thp_pkg::ctx_t ctx_i,   // pnum / pden hold the magnitudes
  output logic          valid_o,
  output thp_pkg::ctx_t ctx_o    // pq holds the quotient
);

  localparam int N = thp_pkg::DIV_STEPS;

  logic          v_q [N];
  thp_pkg::ctx_t c_q [N];
  logic [63:0]   r_q [N];
  logic [63:0]   n_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic          v_in;
    thp_pkg::ctx_t c_in;
    logic [63:0]   r_in, n_in, r_d, n_d;
    logic [64:0]   trial;
    logic          q_bit;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign c_in = ctx_i;
      assign r_in = 64'd0;
      assign n_in = ctx_i.pnum;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign c_in = c_q[k-1];
      assign r_in = r_q[k-1];
      assign n_in = n_q[k-1];
    end

    always_comb begin
      trial = {r_in, n_in[63]} - {1'b0, c_in.pden};
      q_bit = ~trial[64];
      r_d   = q_bit ? trial[63:0] : {r_in[62:0], n_in[63]};
      n_d   = {n_in[62:0], q_bit};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k] <= c_in;
        r_q[k] <= r_d;
        n_q[k] <= n_d;
      end
    end
  end

  always_comb begin
    ctx_o    = c_q[N-1];
    ctx_o.pq = n_q[N-1];
  end

  assign valid_o = v_q[N-1];

endmodule

>>> rtl/thp_sensor_compensation.sv
// ----------------------------------------------------------------------------
// thp_sensor_compensation
// throughput: one request per cycle unless the output stalls; the divider is fully pipelined
// a stalled result holds the whole pipeline, nothing is dropped or repeated
// reset: asynchronous active low, clears coefficient registers and valid bits
// ----------------------------------------------------------------------------
module thp_sensor_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // temp_centi[15:0], press_q24_8[47:16],
                                       // hum_q22_10[64:48], zero pad[71:65]
  output logic        m_axis_tuser_o   // press_div_zero
);

  // --------------------------------------------------------------------------
  // coefficient registers
  // --------------------------------------------------------------------------
  logic [63:0] temp_q, press_lo_q, press_hi_q, mixed_q;
  logic [23:0] hum_q;
  logic [18:0] fine_off_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q     <= '0;
      press_lo_q <= '0;
      press_hi_q <= '0;
      mixed_q    <= '0;
      hum_q      <= '0;
      fine_off_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        thp_pkg::REG_TEMP:     temp_q     <= cfg_data_i;
        thp_pkg::REG_PRESS_LO: press_lo_q <= cfg_data_i;
        thp_pkg::REG_PRESS_HI: press_hi_q <= cfg_data_i;
        thp_pkg::REG_MIXED:    mixed_q    <= cfg_data_i;
        thp_pkg::REG_HUM:      hum_q      <= cfg_data_i[23:0];
        thp_pkg::REG_FINE_OFF: fine_off_q <= cfg_data_i[18:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // unpacked calibration words, all widened to 64 bits
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6, off;

  assign t1  = {48'd0, temp_q[15:0]};
  assign t2  = 64'($signed(temp_q[31:16]));
  assign t3  = 64'($signed(temp_q[47:32]));
  assign p1  = {48'd0, press_lo_q[15:0]};
  assign p2  = 64'($signed(press_lo_q[31:16]));
  assign p3  = 64'($signed(press_lo_q[47:32]));
  assign p4  = 64'($signed(press_lo_q[63:48]));
  assign p5  = 64'($signed(press_hi_q[15:0]));
  assign p6  = 64'($signed(press_hi_q[31:16]));
  assign p7  = 64'($signed(press_hi_q[47:32]));
  assign p8  = 64'($signed(press_hi_q[63:48]));
  assign p9  = 64'($signed(mixed_q[15:0]));
  assign h1  = {56'd0, mixed_q[23:16]};
  assign h2  = 64'($signed(mixed_q[39:24]));
  assign h3  = {56'd0, mixed_q[47:40]};
  assign h6  = 64'($signed(mixed_q[55:48]));
  assign h4  = 64'($signed(hum_q[11:0]));
  assign h5  = 64'($signed(hum_q[23:12]));
  assign off = 64'($signed(fine_off_q));

  // --------------------------------------------------------------------------
  // pipeline advance: every stage moves unless the result register is stuck
  // --------------------------------------------------------------------------
  logic adv;
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  thp_pkg::ctx_t c0_d, c0_q, c1_d, c1_q, c2_d, c2_q, c3_d, c3_q, c4_d, c4_q;
  thp_pkg::ctx_t c5_d, c5_q, c6_d, c6_q, c7_d, c7_q, c8_d, c8_q, c9_d, c9_q;
  thp_pkg::ctx_t c10_d, c10_q, c11_d, c11_q;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;

  // multiply stage wiring
  thp_pkg::mvec_t m1_a, m1_b, m1_p, m2_a, m2_b, m2_p, m3_a, m3_b, m3_p;
  thp_pkg::mvec_t m4_a, m4_b, m4_p, m5_a, m5_b, m5_p, m6_a, m6_b, m6_p;
  thp_pkg::mvec_t m7_a, m7_b, m7_p, m8_a, m8_b, m8_p;
  thp_pkg::ctx_t  m1_c, m2_c, m3_c, m4_c, m5_c, m6_c, m7_c, m8_c, dv_c;
  logic           m1_v, m2_v, m3_v, m4_v, m5_v, m6_v, m7_v, m8_v, dv_v;

  // input capture
  always_comb begin
    c0_d       = '0;
    c0_d.adc_t = s_axis_tdata_i[19:0];
    c0_d.adc_p = s_axis_tdata_i[39:20];
    c0_d.adc_h = s_axis_tdata_i[55:40];
  end

  // temperature: linear and square terms
  always_comb begin
    logic [63:0] d;
    d    = 64'(c0_q.adc_t[19:4]) - t1;
    m1_a = '0;
    m1_b = '0;
    m1_a[0] = 64'(c0_q.adc_t[19:3]) - (t1 << 1);
    m1_b[0] = t2;
    m1_a[1] = d;
    m1_b[1] = d;
  end

  thp_mul_stage u_m1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v0_q), .ctx_i(c0_q),
    .a_i(m1_a), .b_i(m1_b), .valid_o(m1_v), .ctx_o(m1_c), .prod_o(m1_p)
  );

  always_comb begin
    c1_d    = m1_c;
    c1_d.ta = 64'($signed(m1_p[0]) >>> 11);
    c1_d.pa = 64'($signed(m1_p[1]) >>> 12);
  end

  // square term times T3
  always_comb begin
    m2_a    = '0;
    m2_b    = '0;
    m2_a[0] = c1_q.pa;
    m2_b[0] = t3;
  end

  thp_mul_stage u_m2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v1_q), .ctx_i(c1_q),
    .a_i(m2_a), .b_i(m2_b), .valid_o(m2_v), .ctx_o(m2_c), .prod_o(m2_p)
  );

  // fine temperature including the programmable offset
  always_comb begin
    c2_d    = m2_c;
    c2_d.tf = m2_c.ta + 64'($signed(m2_p[0]) >>> 14) + off;
  end

  // first pressure and humidity products off fine temperature
  always_comb begin
    logic [63:0] a, x;
    a    = c2_q.tf - 64'd128000;
    x    = c2_q.tf - 64'd76800;
    m3_a = '0;
    m3_b = '0;
    m3_a[0] = a;  m3_b[0] = a;
    m3_a[1] = a;  m3_b[1] = p5;
    m3_a[2] = a;  m3_b[2] = p2;
    m3_a[3] = x;  m3_b[3] = h6;
    m3_a[4] = x;  m3_b[4] = h3;
    m3_a[5] = h5; m3_b[5] = x;
  end

  thp_mul_stage u_m3 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q), .ctx_i(c2_q),
    .a_i(m3_a), .b_i(m3_b), .valid_o(m3_v), .ctx_o(m3_c), .prod_o(m3_p)
  );

  // temperature result with saturation, partial pressure and humidity terms
  always_comb begin
    logic [63:0] tv;
    tv   = 64'($signed((m3_c.tf << 2) + m3_c.tf + 64'd128) >>> 8);
    c3_d = m3_c;
    if ($signed(tv) > 64'sd32767) begin
      c3_d.temp = 16'h7fff;
    end else if ($signed(tv) < -64'sd32768) begin
      c3_d.temp = 16'h8000;
    end else begin
      c3_d.temp = tv[15:0];
    end
    c3_d.pa = m3_p[0];
    c3_d.pb = (m3_p[1] << 17) + (p4 << 35);
    c3_d.ta = m3_p[2] << 12;
    c3_d.hu = 64'($signed({34'd0, m3_c.adc_h, 14'd0} - (h4 << 20) - m3_p[5]
                           + 64'd16384) >>> 15);
    c3_d.hv = 64'($signed(m3_p[3]) >>> 10);
    c3_d.hw = 64'($signed(m3_p[4]) >>> 11);
  end

  always_comb begin
    m4_a    = '0;
    m4_b    = '0;
    m4_a[0] = c3_q.pa;  m4_b[0] = p6;
    m4_a[1] = c3_q.pa;  m4_b[1] = p3;
    m4_a[2] = c3_q.hv;  m4_b[2] = c3_q.hw + 64'd32768;
  end

  thp_mul_stage u_m4 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v3_q), .ctx_i(c3_q),
    .a_i(m4_a), .b_i(m4_b), .valid_o(m4_v), .ctx_o(m4_c), .prod_o(m4_p)
  );

  always_comb begin
    c4_d    = m4_c;
    c4_d.pb = m4_p[0] + m4_c.pb;
    c4_d.pa = 64'($signed(m4_p[1]) >>> 8) + m4_c.ta;
    c4_d.hw = 64'($signed(m4_p[2]) >>> 10) + 64'd2097152;
  end

  // divisor scale, numerator, humidity gain
  always_comb begin
    logic [63:0] pp;
    pp   = 64'd1048576 - 64'(c4_q.adc_p);
    m5_a = '0;
    m5_b = '0;
    m5_a[0] = (64'd1 << 47) + c4_q.pa;  m5_b[0] = p1;
    m5_a[1] = c4_q.hw;                  m5_b[1] = h2;
    m5_a[2] = (pp << 31) - c4_q.pb;     m5_b[2] = 64'd3125;
  end

  thp_mul_stage u_m5 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v4_q), .ctx_i(c4_q),
    .a_i(m5_a), .b_i(m5_b), .valid_o(m5_v), .ctx_o(m5_c), .prod_o(m5_p)
  );

  always_comb begin
    c5_d      = m5_c;
    c5_d.pden = 64'($signed(m5_p[0]) >>> 33);
    c5_d.hv   = 64'($signed(m5_p[1] + 64'd8192) >>> 14);
    c5_d.pnum = m5_p[2];
  end

  // humidity product u*v, alongside the divider setup
  always_comb begin
    m6_a    = '0;
    m6_b    = '0;
    m6_a[0] = c5_q.hu;
    m6_b[0] = c5_q.hv;
  end

  thp_mul_stage u_m6 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v5_q), .ctx_i(c5_q),
    .a_i(m6_a), .b_i(m6_b), .valid_o(m6_v), .ctx_o(m6_c), .prod_o(m6_p)
  );

  // sign split for the magnitude divider
  always_comb begin
    c6_d      = m6_c;
    c6_d.hx   = m6_p[0];
    c6_d.dz   = (m6_c.pden == 64'd0);
    c6_d.qneg = m6_c.pnum[63] ^ m6_c.pden[63];
    c6_d.pnum = m6_c.pnum[63] ? 64'd0 - m6_c.pnum : m6_c.pnum;
    c6_d.pden = m6_c.pden[63] ? 64'd0 - m6_c.pden : m6_c.pden;
  end

  thp_div u_div (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v6_q), .ctx_i(c6_q),
    .valid_o(dv_v), .ctx_o(dv_c)
  );

  // restore the quotient sign, truncation toward zero
  always_comb begin
    c7_d    = dv_c;
    c7_d.pq = dv_c.qneg ? 64'd0 - dv_c.pq : dv_c.pq;
  end

  // pressure correction terms and humidity square
  always_comb begin
    logic [63:0] q, s;
    q    = 64'($signed(c7_q.pq) >>> 13);
    s    = 64'($signed(c7_q.hx) >>> 15);
    m7_a = '0;
    m7_b = '0;
    m7_a[0] = p9;  m7_b[0] = q;
    m7_a[1] = p8;  m7_b[1] = c7_q.pq;
    m7_a[2] = s;   m7_b[2] = s;
  end

  thp_mul_stage u_m7 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v7_q), .ctx_i(c7_q),
    .a_i(m7_a), .b_i(m7_b), .valid_o(m7_v), .ctx_o(m7_c), .prod_o(m7_p)
  );

  always_comb begin
    c8_d    = m7_c;
    c8_d.pa = m7_p[0];
    c8_d.pb = 64'($signed(m7_p[1]) >>> 19);
    c8_d.hw = 64'($signed(m7_p[2]) >>> 7);
  end

  always_comb begin
    m8_a    = '0;
    m8_b    = '0;
    m8_a[0] = c8_q.pa;  m8_b[0] = 64'($signed(c8_q.pq) >>> 13);
    m8_a[1] = c8_q.hw;  m8_b[1] = h1;
  end

  thp_mul_stage u_m8 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v8_q), .ctx_i(c8_q),
    .a_i(m8_a), .b_i(m8_b), .valid_o(m8_v), .ctx_o(m8_c), .prod_o(m8_p)
  );

  always_comb begin
    c9_d    = m8_c;
    c9_d.pa = 64'($signed(m8_p[0]) >>> 25);
    c9_d.hx = m8_c.hx - 64'($signed(m8_p[1]) >>> 4);
  end

  // pressure sum, humidity clamp to 0..100 percent then drop 12 bits
  always_comb begin
    c10_d    = c9_q;
    c10_d.pq = c9_q.pq + c9_q.pa + c9_q.pb;
    if (c9_q.hx[63]) begin
      c10_d.hres = '0;
    end else if (c9_q.hx > 64'd419430400) begin
      c10_d.hres = 17'd102400;
    end else begin
      c10_d.hres = c9_q.hx[28:12];
    end
  end

  // final pressure scaling and saturation, zero divisor forces 0
  always_comb begin
    logic [63:0] pv;
    pv    = 64'($signed(c10_q.pq) >>> 8) + (p7 << 4);
    c11_d = c10_q;
    if (c10_q.dz || pv[63]) begin
      c11_d.pres = '0;
    end else if (pv[63:32] != 32'd0) begin
      c11_d.pres = 32'hffff_ffff;
    end else begin
      c11_d.pres = pv[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else if (adv) begin
      v0_q  <= s_axis_tvalid_i;
      v1_q  <= m1_v;
      v2_q  <= m2_v;
      v3_q  <= m3_v;
      v4_q  <= m4_v;
      v5_q  <= m5_v;
      v6_q  <= m6_v;
      v7_q  <= dv_v;
      v8_q  <= m7_v;
      v9_q  <= m8_v;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0_q  <= c0_d;
      c1_q  <= c1_d;
      c2_q  <= c2_d;
      c3_q  <= c3_d;
      c4_q  <= c4_d;
      c5_q  <= c5_d;
      c6_q  <= c6_d;
      c7_q  <= c7_d;
      c8_q  <= c8_d;
      c9_q  <= c9_d;
      c10_q <= c10_d;
      c11_q <= c11_d;
    end
  end

  // result register drives the output stream directly
  assign m_axis_tvalid_o = v11_q;
  assign m_axis_tdata_o  = {7'd0, c11_q.hres, c11_q.pres, c11_q.temp};
  assign m_axis_tuser_o  = c11_q.dz;

endmodule

>>> rtl/thp_chk.sv
// ----------------------------------------------------------------------------
// thp_chk
// port-level checks for the sensor compensation block
// ----------------------------------------------------------------------------
module thp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [63:0] cfg_data_i,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [55:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // the input side only waits when a result is held back
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // zero divisor flag forces zero pressure
  a_dz_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[47:16] == 32'd0)
    else $error("pressure nonzero with divisor flag");

  // humidity stays inside the clamp range, pad bits stay zero
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[64:48] <= 17'd102400 && m_axis_tdata_o[71:65] == 7'd0)
    else $error("humidity out of range");

endmodule

bind thp_sensor_compensation thp_chk u_thp_chk (.*);

>>> tb/sv/thp_comp_checker.sv
// ----------------------------------------------------------------------------
// thp_comp_checker
// watches the config, input and output channels, computes the compensated
// temperature, pressure and humidity for every accepted request and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module thp_comp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [55:0] in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [71:0] out_data_i,
  input  logic        out_user_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] temp;
    logic [31:0] pres;
    logic [16:0] hum;
    logic        dz;
  } comp_res_t;

  logic [63:0] temp_c, plo_c, phi_c, mix_c;
  logic [23:0] hum_c;
  logic [18:0] off_c;
  comp_res_t   expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic signed [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] sdiv64(logic signed [63:0] n,
                                                logic signed [63:0] d);
    logic [63:0] an, ad, q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q  = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_res_t compensate(logic [19:0] adc_t, logic [19:0] adc_p,
                                           logic [15:0] adc_h);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] h1, h2, h3, h4, h5, h6, off;
    logic signed [63:0] a, b, d, tf, p, q, x, s, u, v, w;
    comp_res_t r;
    t1 = {48'd0, temp_c[15:0]};  t2 = sx16(temp_c[31:16]);  t3 = sx16(temp_c[47:32]);
    p1 = {48'd0, plo_c[15:0]};   p2 = sx16(plo_c[31:16]);
    p3 = sx16(plo_c[47:32]);     p4 = sx16(plo_c[63:48]);
    p5 = sx16(phi_c[15:0]);      p6 = sx16(phi_c[31:16]);
    p7 = sx16(phi_c[47:32]);     p8 = sx16(phi_c[63:48]);
    p9 = sx16(mix_c[15:0]);      h1 = {56'd0, mix_c[23:16]};
    h2 = sx16(mix_c[39:24]);     h3 = {56'd0, mix_c[47:40]};
    h6 = {{56{mix_c[55]}}, mix_c[55:48]};
    h4 = {{52{hum_c[11]}}, hum_c[11:0]};
    h5 = {{52{hum_c[23]}}, hum_c[23:12]};
    off = {{45{off_c[18]}}, off_c};

    // temperature, fine value carried into the other two paths
    a  = (($signed({44'd0, adc_t} >> 3) - (t1 <<< 1)) * t2) >>> 11;
    d  = $signed({44'd0, adc_t} >> 4) - t1;
    b  = (((d * d) >>> 12) * t3) >>> 14;
    tf = a + b + off;
    s  = (tf * 5 + 128) >>> 8;
    r.temp = (s > 32767) ? 16'h7fff : (s < -32768) ? 16'h8000 : s[15:0];

    // pressure
    a = tf - 128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      r.pres = '0;
      r.dz   = 1'b1;
    end else begin
      p = 64'sd1048576 - $signed({44'd0, adc_p});
      p = sdiv64(((p <<< 31) - b) * 3125, a);
      q = p >>> 13;
      x = (p9 * q * q) >>> 25;
      w = (p8 * p) >>> 19;
      p = ((p + x + w) >>> 8) + (p7 <<< 4);
      r.pres = (p < 0) ? '0 : (p > 64'sh0ffff_ffff) ? 32'hffff_ffff : p[31:0];
      r.dz   = 1'b0;
    end

    // humidity
    x = tf - 76800;
    u = (($signed({48'd0, adc_h}) <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
    v = (x * h6) >>> 10;
    w = (x * h3) >>> 11;
    w = ((v * (w + 32768)) >>> 10) + 2097152;
    v = (w * h2 + 8192) >>> 14;
    x = u * v;
    s = x >>> 15;
    x = x - ((((s * s) >>> 7) * h1) >>> 4);
    if (x < 0) x = 0;
    if (x > 419430400) x = 419430400;
    x = x / 4096;
    r.hum = x[16:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    comp_res_t e;
    if (!rst_ni) begin
      temp_c <= '0; plo_c <= '0; phi_c <= '0; mix_c <= '0; hum_c <= '0; off_c <= '0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          thp_pkg::REG_TEMP:     temp_c <= cfg_data_i;
          thp_pkg::REG_PRESS_LO: plo_c  <= cfg_data_i;
          thp_pkg::REG_PRESS_HI: phi_c  <= cfg_data_i;
          thp_pkg::REG_MIXED:    mix_c  <= cfg_data_i;
          thp_pkg::REG_HUM:      hum_c  <= cfg_data_i[23:0];
          thp_pkg::REG_FINE_OFF: off_c  <= cfg_data_i[18:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(compensate(in_data_i[19:0], in_data_i[39:20],
                                        in_data_i[55:40]));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_data_i[63:0], '0);
        end else begin
          e = expected_q.pop_front();
          if (out_data_i[15:0] !== e.temp) report_mismatch("temp", out_data_i[15:0], e.temp);
          if (out_data_i[47:16] !== e.pres) report_mismatch("press", out_data_i[47:16], e.pres);
          if (out_data_i[64:48] !== e.hum) report_mismatch("hum", out_data_i[64:48], e.hum);
          if (out_user_i !== e.dz) report_mismatch("div_zero", out_user_i, e.dz);
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_thp_sensor_compensation.sv
// ----------------------------------------------------------------------------
// tb_thp_sensor_compensation
// drives coefficient settings and raw sample requests with random gaps and
// output stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_thp_sensor_compensation;

  localparam int LATENCY = 92;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;  // raw_temp, raw_press, raw_hum from bit 0
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;       // temp_centi, press_q24_8, hum_q22_10, pad
  logic        m_axis_tuser_o;       // press_div_zero
  int          fail_count, pending;
  bit          calm;                 // no idling while set

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  thp_sensor_compensation u_dut (.*);

  thp_comp_checker u_chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid_i), .in_ready_i(s_axis_tready_o), .in_data_i(s_axis_tdata_i),
    .out_valid_i(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_data_i(m_axis_tdata_o), .out_user_i(m_axis_tuser_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // output side stalls at random with a 17 percent chance, except in calm stretches
  always @(posedge clk_i)
    m_axis_tready_i <= calm || ($urandom_range(99) >= 17);

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // one sample request; an idle gap goes ahead of it at random
  // valid stays up after the request so back to back requests need no gap
  task automatic send_sample(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {h, p, t};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // coefficients of a typical part, with random spread on top
  function automatic logic [63:0] jitter(logic [63:0] base);
    return base ^ {8'd0, 2'($urandom_range(3)), 14'd0, 8'($urandom_range(255)), 8'd0,
                   8'($urandom_range(255)), 8'd0, 4'($urandom_range(15)), 4'd0};
  endfunction

  task automatic load_typical;
    write_reg(thp_pkg::REG_TEMP,     {16'd0, 16'hffce, 16'h6a5e, 16'h6f84});
    write_reg(thp_pkg::REG_PRESS_LO, {16'h1c4e, 16'h0bd0, 16'hd6b6, 16'h8e43});
    write_reg(thp_pkg::REG_PRESS_HI, {16'h1770, 16'hfff9, 16'hfff9, 16'h0039});
    write_reg(thp_pkg::REG_MIXED,    {8'd0, 8'h1e, 8'h00, 16'h0167, 8'h4b, 16'h1770});
    write_reg(thp_pkg::REG_HUM,      {40'd0, 12'h000, 12'h146});
    write_reg(thp_pkg::REG_FINE_OFF, 64'd0);
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [19:0] rt, rp;
    logic [15:0] rh;
    calm = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all-zero coefficients: the pressure divisor is zero
    send_sample('0, '0, '0);
    send_sample(20'hfffff, 20'hfffff, 16'hffff);
    drain();

    // typical part, field extremes and mid values
    load_typical();
    send_sample('0, '0, '0);
    send_sample(20'hfffff, 20'hfffff, 16'hffff);
    send_sample(20'h7f000, 20'h5a000, 16'h6a00);
    send_sample(20'h80000, 20'h80000, 16'h8000);
    send_sample(20'h55555, 20'haaaaa, 16'h5555);
    send_sample(20'haaaaa, 20'h55555, 16'haaaa);
    drain();

    // extreme registers: saturation and wrap paths
    write_reg(thp_pkg::REG_FINE_OFF, 64'h3ffff);
    send_sample(20'hfffff, 20'h00000, 16'hffff);
    drain();
    write_reg(thp_pkg::REG_FINE_OFF, 64'h40000);
    drain();
    send_sample(20'h00000, 20'hfffff, 16'h0000);
    drain();
    write_reg(thp_pkg::REG_TEMP, '1);
    write_reg(thp_pkg::REG_PRESS_LO, '1);
    write_reg(thp_pkg::REG_PRESS_HI, '1);
    write_reg(thp_pkg::REG_MIXED, '1);
    write_reg(thp_pkg::REG_HUM, '1);
    drain();
    send_sample(20'hfffff, 20'hfffff, 16'hffff);
    send_sample('0, '0, '0);
    drain();
    write_reg(thp_pkg::REG_TEMP, {16'd0, 16'h7fff, 16'h7fff, 16'hffff});
    write_reg(thp_pkg::REG_PRESS_LO, {16'h7fff, 16'h7fff, 16'h7fff, 16'h0001});
    write_reg(thp_pkg::REG_PRESS_HI, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    write_reg(thp_pkg::REG_MIXED, {8'd0, 8'h7f, 8'hff, 16'h8000, 8'hff, 16'h7fff});
    write_reg(thp_pkg::REG_HUM, {40'd0, 12'h800, 12'h7ff});
    drain();
    send_sample(20'h12345, 20'h00001, 16'h0001);
    send_sample(20'hfffff, 20'hfffff, 16'hffff);
    drain();

    // random phases: mostly near-typical parts, some fully random sets
    for (int ph = 0; ph < 17; ph++) begin
      drain();
      calm = (ph == 3);
      if (ph % 4 == 3) begin
        write_reg(thp_pkg::REG_TEMP, {$urandom, $urandom});
        write_reg(thp_pkg::REG_PRESS_LO, {$urandom, $urandom});
        write_reg(thp_pkg::REG_PRESS_HI, {$urandom, $urandom});
        write_reg(thp_pkg::REG_MIXED, {$urandom, $urandom});
        write_reg(thp_pkg::REG_HUM, {40'd0, 24'($urandom)});
      end else begin
        load_typical();
        write_reg(thp_pkg::REG_TEMP, jitter({16'd0, 16'hffce, 16'h6a5e, 16'h6f84}));
        write_reg(thp_pkg::REG_PRESS_LO, jitter({16'h1c4e, 16'h0bd0, 16'hd6b6, 16'h8e43}));
        write_reg(thp_pkg::REG_PRESS_HI, jitter({16'h1770, 16'hfff9, 16'hfff9, 16'h0039}));
        write_reg(thp_pkg::REG_MIXED,
                  jitter({8'd0, 8'h1e, 8'h00, 16'h0167, 8'h4b, 16'h1770}));
      end
      write_reg(thp_pkg::REG_FINE_OFF, {45'd0, 19'($urandom)});
      for (int n = 0; n < 100; n++) begin
        // realistic converter words most of the time, full range otherwise
        if ($urandom_range(3) != 0) begin
          rt = 20'($urandom_range(20'hb0000, 20'h50000));
          rp = 20'($urandom_range(20'ha0000, 20'h30000));
          rh = 16'($urandom_range(16'he000, 16'h2000));
        end else begin
          rt = 20'($urandom);
          rp = 20'($urandom);
          rh = 16'($urandom);
        end
        send_sample(rt, rp, rh);
      end
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/thp_pkg.sv
rtl/thp_mul_stage.sv
rtl/thp_div.sv
rtl/thp_sensor_compensation.sv
rtl/thp_chk.sv
tb/sv/thp_comp_checker.sv
tb/sv/tb_thp_sensor_compensation.sv
